// ===== hdl/i2cms_pkg.sv =====
// shared types, constants and step tables for the i2c master byte sequencer
`default_nettype none

package i2cms_pkg;

   localparam int unsigned QueueDepthDefault = 4;
   localparam logic [15:0] AckTimeoutReset   = 16'd100;
   localparam logic [15:0] WaitMax           = 16'hFFFF;

   typedef enum logic [2:0] {
      KIND_START_WR = 3'd0,
      KIND_START_RD = 3'd1,
      KIND_WRITE    = 3'd2,
      KIND_READ     = 3'd3,
      KIND_STOP     = 3'd4,
      KIND_TICK     = 3'd5
   } kind_type;

   localparam logic [1:0] RK_PIN    = 2'd0;
   localparam logic [1:0] RK_ACK    = 2'd1;
   localparam logic [1:0] RK_DATA   = 2'd2;
   localparam logic [1:0] RK_REJECT = 2'd3;

   typedef enum logic [3:0] {
      OP_REJECT     = 4'd0,
      OP_START      = 4'd1,
      OP_WRITE      = 4'd2,
      OP_READ_EMPTY = 4'd3,
      OP_READ_BEGIN = 4'd4,
      OP_STOP       = 4'd5,
      OP_ACK        = 4'd6,
      OP_READ_BIT   = 4'd7,
      OP_READ_END   = 4'd8
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] value;
      logic       flag;
   } job_type;

   typedef enum logic [3:0] {
      ACT_SCL0 = 4'd0,
      ACT_SCL1 = 4'd1,
      ACT_DRV0 = 4'd2,
      ACT_DRV1 = 4'd3,
      ACT_DRVB = 4'd4,
      ACT_REL  = 4'd5,
      ACT_REJ  = 4'd6,
      ACT_ACK  = 4'd7,
      ACT_DATA = 4'd8
   } act_type;

   typedef struct packed {
      act_type act;
      logic    done;
   } step_type;

   // fixed step lists for the short jobs; flag selects ack or final-byte tail on read end
   function automatic step_type list_step(op_type op, logic flag, logic [3:0] idx);
      step_type s;
      s.act  = ACT_REJ;
      s.done = 1'b1;
      case (op)
         OP_REJECT:     s = '{ACT_REJ, 1'b1};
         OP_READ_EMPTY: s = '{ACT_DATA, 1'b1};
         OP_ACK:        s = '{ACT_ACK, 1'b1};
         OP_START:      s = '{ACT_DRV0, 1'b1};
         OP_READ_BEGIN: begin
            case (idx)
               4'd0:    s = '{ACT_REL, 1'b0};
               4'd1:    s = '{ACT_SCL0, 1'b0};
               default: s = '{ACT_SCL1, 1'b1};
            endcase
         end
         OP_STOP: begin
            case (idx)
               4'd0:    s = '{ACT_SCL0, 1'b0};
               4'd1:    s = '{ACT_DRV0, 1'b0};
               4'd2:    s = '{ACT_SCL1, 1'b0};
               default: s = '{ACT_DRV1, 1'b1};
            endcase
         end
         OP_READ_BIT: begin
            case (idx)
               4'd0:    s = '{ACT_SCL0, 1'b0};
               default: s = '{ACT_SCL1, 1'b1};
            endcase
         end
         OP_READ_END: begin
            if (flag) begin
               case (idx)
                  4'd0:    s = '{ACT_SCL0, 1'b0};
                  4'd1:    s = '{ACT_DRV0, 1'b0};
                  4'd2:    s = '{ACT_SCL1, 1'b0};
                  4'd3:    s = '{ACT_SCL0, 1'b0};
                  default: s = '{ACT_DATA, 1'b1};
               endcase
            end else begin
               case (idx)
                  4'd0:    s = '{ACT_SCL0, 1'b0};
                  4'd1:    s = '{ACT_DRV1, 1'b0};
                  4'd2:    s = '{ACT_SCL1, 1'b0};
                  4'd3:    s = '{ACT_SCL0, 1'b0};
                  4'd4:    s = '{ACT_SCL0, 1'b0};
                  4'd5:    s = '{ACT_DRV0, 1'b0};
                  4'd6:    s = '{ACT_SCL1, 1'b0};
                  4'd7:    s = '{ACT_DRV1, 1'b0};
                  default: s = '{ACT_DATA, 1'b1};
               endcase
            end
         end
         default: s = '{ACT_REJ, 1'b1};
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/i2cms_front.sv =====
// front end: accepts items, tracks bus protocol phase and queues jobs
`default_nettype none

module i2cms_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_push,
   output logic                    req_full,
   input  wire  [2:0]              req_kind,
   input  wire  [6:0]              req_address,
   input  wire  [7:0]              req_data,
   input  wire  [7:0]              req_read_count,
   input  wire                     req_sda_line,
   input  wire                     csr_wr_en,
   input  wire  [15:0]             csr_wr_data,
   output logic                    q_push,
   output i2cms_pkg::job_type      q_job,
   input  wire                     q_full
);
   import i2cms_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_ACK  = 3'b010,
      PH_READ = 3'b100
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  left_ff, left_in;
   logic [15:0] wait_ff, wait_in;
   logic [15:0] timeout_ff;
   logic        accept;
   logic [15:0] wait_inc;
   logic [7:0]  shift_nx;
   logic [3:0]  bit_inc;
   logic [7:0]  left_dec;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   always_comb begin
      phase_in = phase_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      wait_in  = wait_ff;
      q_push   = 1'b0;
      q_job    = '{op: OP_REJECT, value: 8'd0, flag: 1'b0};
      wait_inc = (wait_ff == WaitMax) ? wait_ff : wait_ff + 16'd1;
      shift_nx = {shift_ff[6:0], req_sda_line};
      bit_inc  = bit_ff + 4'd1;
      left_dec = left_ff - 8'd1;
      if (accept) begin
         if ((req_kind inside {[KIND_START_WR:KIND_STOP]}) && phase_ff != PH_IDLE) begin
            q_push = 1'b1;
         end else begin
            case (req_kind)
               KIND_START_WR, KIND_START_RD: begin
                  q_push   = 1'b1;
                  q_job.op = OP_START;
                  q_job.value = {req_address, req_kind[0]};
                  if (req_kind[0]) begin
                     left_in = req_read_count;
                  end
                  phase_in = PH_ACK;
                  wait_in  = 16'd0;
               end
               KIND_WRITE: begin
                  q_push      = 1'b1;
                  q_job.op    = OP_WRITE;
                  q_job.value = req_data;
                  phase_in    = PH_ACK;
                  wait_in     = 16'd0;
               end
               KIND_READ: begin
                  q_push = 1'b1;
                  if (left_ff == 8'd0) begin
                     q_job.op = OP_READ_EMPTY;
                  end else begin
                     q_job.op = OP_READ_BEGIN;
                     shift_in = 8'd0;
                     bit_in   = 4'd0;
                     phase_in = PH_READ;
                  end
               end
               KIND_STOP: begin
                  q_push   = 1'b1;
                  q_job.op = OP_STOP;
               end
               KIND_TICK: begin
                  if (phase_ff == PH_ACK) begin
                     if (!req_sda_line) begin
                        phase_in   = PH_IDLE;
                        q_push     = 1'b1;
                        q_job.op   = OP_ACK;
                        q_job.flag = 1'b1;
                     end else begin
                        wait_in = wait_inc;
                        if (wait_inc >= timeout_ff) begin
                           phase_in = PH_IDLE;
                           q_push   = 1'b1;
                           q_job.op = OP_ACK;
                        end
                     end
                  end else if (phase_ff == PH_READ) begin
                     shift_in = shift_nx;
                     q_push   = 1'b1;
                     if (bit_inc < 4'd8) begin
                        bit_in   = bit_inc;
                        q_job.op = OP_READ_BIT;
                     end else begin
                        bit_in      = 4'd0;
                        phase_in    = PH_IDLE;
                        left_in     = left_dec;
                        q_job.op    = OP_READ_END;
                        q_job.value = shift_nx;
                        q_job.flag  = (left_dec != 8'd0);
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         bit_ff     <= 4'd0;
         shift_ff   <= 8'd0;
         left_ff    <= 8'd0;
         wait_ff    <= 16'd0;
         timeout_ff <= AckTimeoutReset;
      end else begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         left_ff  <= left_in;
         wait_ff  <= wait_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/i2cms_queue.sv =====
// short job queue between front and back ends
`default_nettype none

module i2cms_queue #(
   parameter int unsigned DEPTH = i2cms_pkg::QueueDepthDefault
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  i2cms_pkg::job_type  push_job,
   output logic                full,
   input  wire                 pop,
   output logic                head_valid,
   output i2cms_pkg::job_type  head_job
);
   import i2cms_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   job_type         slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (count_ff == CntW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/i2cms_back.sv =====
// back end: steps through each job one result a cycle while results are taken, and holds the pin state
`default_nettype none

module i2cms_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 q_valid,
   input  i2cms_pkg::job_type  q_job,
   output logic                q_pop,
   output logic                rsp_empty,
   input  wire                 rsp_pop,
   output logic [1:0]          rsp_result_kind,
   output logic                rsp_scl_level,
   output logic                rsp_sda_driven,
   output logic                rsp_sda_level,
   output logic                rsp_acked,
   output logic [7:0]          rsp_read_byte,
   output logic                rsp_last
);
   import i2cms_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LIST = 4'b0010,
      S_BITS = 4'b0100,
      S_TAIL = 4'b1000
   } seq_type;

   seq_type    state_ff, state_in;
   job_type    job_ff, job_in;
   logic [3:0] idx_ff, idx_in;
   logic [1:0] sub_ff, sub_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic       scl_ff, scl_in;
   logic       drv_ff, drv_in;
   logic       lvl_ff, lvl_in;
   logic       out_valid_ff, out_valid_in;
   logic [1:0] kind_ff, kind_in;
   logic       acked_ff, acked_in;
   logic [7:0] rbyte_ff, rbyte_in;
   logic       last_ff, last_in;
   step_type   lst;
   act_type    act;
   logic       active;
   logic       final_step;
   logic       adv;
   logic       step;
   logic       load;

   always_comb begin
      lst        = list_step(job_ff.op, job_ff.flag, idx_ff);
      act        = ACT_SCL0;
      active     = 1'b0;
      final_step = 1'b0;
      case (state_ff)
         S_LIST: begin
            active     = 1'b1;
            act        = lst.act;
            final_step = lst.done && (job_ff.op != OP_START);
         end
         S_BITS: begin
            active = 1'b1;
            case (sub_ff)
               2'd0:    act = ACT_SCL0;
               2'd1:    act = ACT_DRVB;
               default: act = ACT_SCL1;
            endcase
         end
         S_TAIL: begin
            active = 1'b1;
            case (sub_ff)
               2'd0:    act = ACT_SCL0;
               2'd1:    act = ACT_REL;
               default: act = ACT_SCL1;
            endcase
            final_step = (sub_ff == 2'd2);
         end
         default: ;
      endcase
      adv  = !out_valid_ff || rsp_pop;
      step = active && adv;
      load = q_valid && (!active || (step && final_step));
   end

   assign q_pop = load;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      idx_in   = idx_ff;
      sub_in   = sub_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      if (step) begin
         case (state_ff)
            S_LIST: begin
               if (lst.done) begin
                  if (job_ff.op == OP_START) begin
                     state_in = S_BITS;
                     sub_in   = 2'd0;
                     bit_in   = 3'd0;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
            S_BITS: begin
               if (sub_ff == 2'd2) begin
                  sub_in = 2'd0;
                  bit_in = bit_ff + 3'd1;
                  if (bit_ff == 3'd7) begin
                     state_in = S_TAIL;
                  end
               end else begin
                  sub_in = sub_ff + 2'd1;
               end
               if (sub_ff == 2'd1) begin
                  shift_in = {shift_ff[6:0], 1'b0};
               end
            end
            S_TAIL: begin
               if (sub_ff == 2'd2) begin
                  state_in = S_IDLE;
               end else begin
                  sub_in = sub_ff + 2'd1;
               end
            end
            default: ;
         endcase
      end
      if (load) begin
         job_in   = q_job;
         idx_in   = 4'd0;
         sub_in   = 2'd0;
         bit_in   = 3'd0;
         shift_in = q_job.value;
         state_in = (q_job.op == OP_WRITE) ? S_BITS : S_LIST;
      end
   end

   always_comb begin
      scl_in       = scl_ff;
      drv_in       = drv_ff;
      lvl_in       = lvl_ff;
      out_valid_in = out_valid_ff;
      kind_in      = kind_ff;
      acked_in     = acked_ff;
      rbyte_in     = rbyte_ff;
      last_in      = last_ff;
      if (adv) begin
         out_valid_in = active;
      end
      if (step) begin
         kind_in  = RK_PIN;
         acked_in = 1'b0;
         rbyte_in = 8'd0;
         last_in  = final_step;
         case (act)
            ACT_SCL0: scl_in = 1'b0;
            ACT_SCL1: scl_in = 1'b1;
            ACT_DRV0: begin
               drv_in = 1'b1;
               lvl_in = 1'b0;
            end
            ACT_DRV1: begin
               drv_in = 1'b1;
               lvl_in = 1'b1;
            end
            ACT_DRVB: begin
               drv_in = 1'b1;
               lvl_in = shift_ff[7];
            end
            ACT_REL:  drv_in = 1'b0;
            ACT_REJ:  kind_in = RK_REJECT;
            ACT_ACK: begin
               kind_in  = RK_ACK;
               acked_in = job_ff.flag;
            end
            ACT_DATA: begin
               kind_in  = RK_DATA;
               rbyte_in = job_ff.value;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         scl_ff       <= 1'b1;
         drv_ff       <= 1'b1;
         lvl_ff       <= 1'b1;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         scl_ff       <= scl_in;
         drv_ff       <= drv_in;
         lvl_ff       <= lvl_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      idx_ff   <= idx_in;
      sub_ff   <= sub_in;
      bit_ff   <= bit_in;
      shift_ff <= shift_in;
      kind_ff  <= kind_in;
      acked_ff <= acked_in;
      rbyte_ff <= rbyte_in;
      last_ff  <= last_in;
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_scl_level   = scl_ff;
   assign rsp_sda_driven  = drv_ff;
   assign rsp_sda_level   = lvl_ff;
   assign rsp_acked       = acked_ff;
   assign rsp_read_byte   = rbyte_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

// ===== hdl/i2c_master_byte_sequencer_top.sv =====
// top level of the i2c master byte sequencer
//
//   channel  direction  handshake              payload
//   req      in         req_push / req_full    kind, address, data, read_count, sda_line
//   rsp      out        rsp_empty / rsp_pop    result_kind, pins, acked, read_byte, last
//   csr      in         csr_wr_en              ack_timeout_ticks
//
// one item accepted per cycle while the job queue has room
// results leave at one per cycle while they are taken, from the back-end step sequencer: a start gives 28,
// a write byte 27, a stop 4, a read byte 3 or 1, a read bit 2, a read end 5 or 9,
// other items 1 or none
// synchronous reset puts the bus in idle with scl high and sda driven high
// a held result stalls the back end only; the front keeps taking items until the queue fills
`default_nettype none

module i2c_master_byte_sequencer_top #(
   parameter int unsigned QUEUE_DEPTH = i2cms_pkg::QueueDepthDefault
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_push,
   output logic        req_full,
   input  wire  [2:0]  req_kind,
   input  wire  [6:0]  req_address,
   input  wire  [7:0]  req_data,
   input  wire  [7:0]  req_read_count,
   input  wire         req_sda_line,
   output logic        rsp_empty,
   input  wire         rsp_pop,
   output logic [1:0]  rsp_result_kind,
   output logic        rsp_scl_level,
   output logic        rsp_sda_driven,
   output logic        rsp_sda_level,
   output logic        rsp_acked,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_last,
   input  wire         csr_wr_en,
   input  wire  [15:0] csr_wr_data
);
   import i2cms_pkg::*;

   logic    q_push;
   job_type q_in_job;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   job_type q_head_job;

   i2cms_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_address    (req_address),
      .req_data       (req_data),
      .req_read_count (req_read_count),
      .req_sda_line   (req_sda_line),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .q_push         (q_push),
      .q_job          (q_in_job),
      .q_full         (q_full)
   );

   i2cms_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_in_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (q_head_job)
   );

   i2cms_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_job           (q_head_job),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_result_kind (rsp_result_kind),
      .rsp_scl_level   (rsp_scl_level),
      .rsp_sda_driven  (rsp_sda_driven),
      .rsp_sda_level   (rsp_sda_level),
      .rsp_acked       (rsp_acked),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// ===== hdl/i2cms_checker.sv =====
// port-level checker for the i2c master byte sequencer, with its bind
`default_nettype none

module i2cms_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_empty,
   input wire       rsp_pop,
   input wire [1:0] rsp_result_kind,
   input wire       rsp_scl_level,
   input wire       rsp_sda_driven,
   input wire       rsp_sda_level,
   input wire       rsp_acked,
   input wire [7:0] rsp_read_byte,
   input wire       rsp_last
);
   import i2cms_pkg::*;

   // no item waits straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result waiting after reset");

   // a stalled item holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_result_kind)
         && $stable(rsp_read_byte) && $stable(rsp_last) && $stable(rsp_scl_level)))
      else $error("stalled result changed");

   // results other than pin steps leave the pins where they were
   a_pins_kept: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop) ##1 (!rsp_empty && rsp_result_kind != RK_PIN)
      |-> (rsp_scl_level == $past(rsp_scl_level) && rsp_sda_driven == $past(rsp_sda_driven)
         && rsp_sda_level == $past(rsp_sda_level)))
      else $error("pins moved on a non pin-step result");

   // acknowledge flag and read byte only on their own result kinds
   a_payload_kind: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((!rsp_acked || rsp_result_kind == RK_ACK)
         && (rsp_read_byte == 8'd0 || rsp_result_kind == RK_DATA)))
      else $error("ack or read byte on wrong result kind");

endmodule

bind i2c_master_byte_sequencer_top i2cms_checker u_checker (.*);

`default_nettype wire
